>>> design/linear_key_value_table_macros.svh
// assertion helpers shared by the table modules
`ifndef LINEAR_KEY_VALUE_TABLE_MACROS_SVH
`define LINEAR_KEY_VALUE_TABLE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LKVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lkvt_pkg.sv
package lkvt_pkg;

    localparam int CAPACITY    = 128;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // operation codes
    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_ACCESS = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
    } entry_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] write_value;
        logic                   write_enable;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   found;
        logic [1:0]             status;
        logic [CNT_W-1:0]       entry_count;
    } result_t;

endpackage

>>> design/lkvt_ram.sv
module lkvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> design/lkvt_engine.sv
`include "linear_key_value_table_macros.svh"

module lkvt_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  lkvt_pkg::cmd_t               cmd,
    output logic                         idle,
    output logic                         res_valid,
    input  logic                         res_ack,
    output lkvt_pkg::result_t            res,
    output logic                         rd_en,
    output logic [lkvt_pkg::ADDR_W-1:0]  rd_addr,
    input  lkvt_pkg::entry_t             rd_data,
    output logic                         wr_en,
    output logic [lkvt_pkg::ADDR_W-1:0]  wr_addr,
    output lkvt_pkg::entry_t             wr_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                             state_reg, state_next;
    logic [lkvt_pkg::CNT_W-1:0]             count_reg, count_next;
    logic [lkvt_pkg::CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic [lkvt_pkg::ADDR_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                                   cmp_valid_reg, cmp_valid_next;
    lkvt_pkg::cmd_t                         cmd_reg;
    logic [lkvt_pkg::VALUE_WIDTH-1:0]       res_value_reg, res_value_next;
    logic                                   res_found_reg, res_found_next;
    logic [1:0]                             res_status_reg, res_status_next;
    logic                                   key_hit;
    logic [lkvt_pkg::VALUE_WIDTH-1:0]       new_value;

    assign key_hit   = cmp_valid_reg && (rd_data.key == cmd_reg.key);
    assign new_value = cmd_reg.write_enable ? cmd_reg.write_value : '0;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
        cmp_idx_reg    <= cmp_idx_next;
        res_value_reg  <= res_value_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
    end

    // scan, shift and result sequencing
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        res_value_next  = res_value_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg[lkvt_pkg::ADDR_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = cmp_idx_reg;
        wr_data         = rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rd_idx_next     = '0;
                    cmp_valid_next  = 1'b0;
                    res_value_next  = '0;
                    res_found_next  = 1'b0;
                    res_status_next = lkvt_pkg::STATUS_OK;
                    if (cmd.kind == lkvt_pkg::KIND_CLEAR)
                    begin
                        count_next = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (key_hit)
                begin
                    res_found_next = 1'b1;
                    state_next     = ST_DONE;
                    case (cmd_reg.kind)
                        lkvt_pkg::KIND_LOOKUP:
                        begin
                            res_value_next = rd_data.value;
                        end
                        lkvt_pkg::KIND_ACCESS:
                        begin
                            if (cmd_reg.write_enable)
                            begin
                                wr_en          = 1'b1;
                                wr_data.key    = cmd_reg.key;
                                wr_data.value  = cmd_reg.write_value;
                                res_value_next = cmd_reg.write_value;
                            end
                            else
                            begin
                                res_value_next = rd_data.value;
                            end
                        end
                        lkvt_pkg::KIND_DELETE:
                        begin
                            rd_idx_next    = lkvt_pkg::CNT_W'(cmp_idx_reg)
                                             + lkvt_pkg::CNT_W'(1);
                            cmp_valid_next = 1'b0;
                            state_next     = ST_SHIFT;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
                else if (rd_idx_reg < count_reg)
                begin
                    // keep one read in flight ahead of the compare
                    rd_en          = 1'b1;
                    cmp_idx_next   = rd_idx_reg[lkvt_pkg::ADDR_W-1:0];
                    cmp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + lkvt_pkg::CNT_W'(1);
                end
                else
                begin
                    // key absent
                    state_next = ST_DONE;
                    case (cmd_reg.kind)
                        lkvt_pkg::KIND_ACCESS:
                        begin
                            if (count_reg == lkvt_pkg::CNT_W'(lkvt_pkg::CAPACITY))
                            begin
                                res_status_next = lkvt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = count_reg[lkvt_pkg::ADDR_W-1:0];
                                wr_data.key    = cmd_reg.key;
                                wr_data.value  = new_value;
                                res_value_next = new_value;
                                count_next     = count_reg + lkvt_pkg::CNT_W'(1);
                            end
                        end
                        lkvt_pkg::KIND_DELETE:
                        begin
                            res_status_next = lkvt_pkg::STATUS_NOT_FOUND;
                        end
                        default:
                        begin
                            res_status_next = lkvt_pkg::STATUS_OK;
                        end
                    endcase
                end
            end

            ST_SHIFT:
            begin
                // move entry read last cycle down one place
                if (cmp_valid_reg)
                begin
                    wr_en = 1'b1;
                end
                if (rd_idx_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = lkvt_pkg::ADDR_W'(rd_idx_reg - lkvt_pkg::CNT_W'(1));
                    cmp_valid_next = 1'b1;
                    rd_idx_next    = rd_idx_reg + lkvt_pkg::CNT_W'(1);
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg)
                    begin
                        count_next = count_reg - lkvt_pkg::CNT_W'(1);
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle              = (state_reg == ST_IDLE);
    assign res_valid         = (state_reg == ST_DONE);
    assign res.value         = res_value_reg;
    assign res.found         = res_found_reg;
    assign res.status        = res_status_reg;
    assign res.entry_count   = count_reg;

    `LKVT_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= lkvt_pkg::CNT_W'(lkvt_pkg::CAPACITY), "entry count above capacity")
    `LKVT_ASSERT_NOW(a_write_state, clk, rst_n, wr_en, (state_reg == ST_SCAN) || (state_reg == ST_SHIFT), "memory write outside scan or shift")
    `LKVT_ASSERT_NOW(a_shift_addr, clk, rst_n, wr_en && (state_reg == ST_SHIFT), lkvt_pkg::CNT_W'(wr_addr) + lkvt_pkg::CNT_W'(1) < count_reg, "shift writes past live entries")
    `LKVT_ASSERT_NEXT(a_clear_empty, clk, rst_n, start && (cmd.kind == lkvt_pkg::KIND_CLEAR), (count_reg == '0) && res_valid, "clear left entries behind")

endmodule

>>> design/linear_key_value_table.sv
// Unordered key-value table of lkvt_pkg::CAPACITY entries, kept packed in insertion order
// in one simple dual-port RAM and searched linearly from entry 0. One operation runs
// at a time: lookup and access read one RAM entry per cycle, with the compare in the
// cycle after each read; a delete also moves the entries after the match down one place.
// A finished result waits in an output register, so the next operation is taken while
// it is still held.
`include "linear_key_value_table_macros.svh"

module linear_key_value_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           kind,
    input  logic signed [lkvt_pkg::KEY_WIDTH-1:0]   key,
    input  logic signed [lkvt_pkg::VALUE_WIDTH-1:0] write_value,
    input  logic                                 write_enable,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [lkvt_pkg::VALUE_WIDTH-1:0] value,
    output logic                                 found,
    output logic [1:0]                           status,
    output logic [lkvt_pkg::CNT_W-1:0]           entry_count
);

    lkvt_pkg::cmd_t              cmd;
    lkvt_pkg::result_t           eng_res;
    lkvt_pkg::result_t           out_res_reg;
    lkvt_pkg::entry_t            ram_rd_data;
    lkvt_pkg::entry_t            ram_wr_data;
    logic [lkvt_pkg::ADDR_W-1:0] ram_rd_addr;
    logic [lkvt_pkg::ADDR_W-1:0] ram_wr_addr;
    logic                        ram_rd_en;
    logic                        ram_wr_en;
    logic                        eng_idle;
    logic                        eng_res_valid;
    logic                        res_ack;
    logic                        start;
    logic                        out_valid_reg, out_valid_next;

    assign cmd.kind         = kind;
    assign cmd.key          = key;
    assign cmd.write_value  = write_value;
    assign cmd.write_enable = write_enable;

    assign in_ready = eng_idle;
    assign start    = in_valid && in_ready;

    lkvt_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_ack   (res_ack),
        .res       (eng_res),
        .rd_en     (ram_rd_en),
        .rd_addr   (ram_rd_addr),
        .rd_data   (ram_rd_data),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data)
    );

    lkvt_ram #(
        .WIDTH ($bits(lkvt_pkg::entry_t)),
        .DEPTH (lkvt_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register takes a result when empty or being drained
    assign res_ack = eng_res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = out_res_reg.value;
    assign found       = out_res_reg.found;
    assign status      = out_res_reg.status;
    assign entry_count = out_res_reg.entry_count;

    `LKVT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, start, !in_ready, "second transfer taken while busy")

endmodule

>>> tb/sv/linear_key_value_table_tb.sv
`timescale 1ns / 100ps

module linear_key_value_table_tb;

    localparam int          KEY_POOL_SIZE = 150;
    localparam int          HOLD_CYCLES   = 600;
    localparam int          SETTLE_CYCLES = 2 * lkvt_pkg::CAPACITY + 40;
    localparam logic [31:0] MOST_NEGATIVE = 32'h8000_0000;
    localparam logic [31:0] MOST_POSITIVE = 32'h7FFF_FFFF;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    in_valid;
    logic                                    in_ready;
    logic [1:0]                              kind;
    logic signed [lkvt_pkg::KEY_WIDTH-1:0]   key;
    logic signed [lkvt_pkg::VALUE_WIDTH-1:0] write_value;
    logic                                    write_enable;
    logic                                    out_valid;
    logic                                    out_ready;
    logic signed [lkvt_pkg::VALUE_WIDTH-1:0] value;
    logic                                    found;
    logic [1:0]                              status;
    logic [lkvt_pkg::CNT_W-1:0]              entry_count;

    // shadow copy of the table contents
    logic [lkvt_pkg::KEY_WIDTH-1:0]   shadow_keys   [lkvt_pkg::CAPACITY];
    logic [lkvt_pkg::VALUE_WIDTH-1:0] shadow_values [lkvt_pkg::CAPACITY];
    int                               shadow_count;

    lkvt_pkg::result_t table_results_due [$];
    logic [31:0]       key_pool [KEY_POOL_SIZE];
    int                mismatch_count;
    bit                steady_mode;
    bit                hold_output;

    linear_key_value_table DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .key          (key),
        .write_value  (write_value),
        .write_enable (write_enable),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .found        (found),
        .status       (status),
        .entry_count  (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit, several times the slowest legal run
    initial
    begin
        #20_000_000;
        $display("linear_key_value_table test failed");
        $finish;
    end

    // apply one operation to the shadow table and return its result
    function automatic lkvt_pkg::result_t apply_table_op(
        input logic [1:0] op,
        input logic [lkvt_pkg::KEY_WIDTH-1:0] k,
        input logic [lkvt_pkg::VALUE_WIDTH-1:0] wv,
        input logic we);
        lkvt_pkg::result_t r;
        int                pos;
        r   = '0;
        pos = -1;
        for (int i = 0; i < shadow_count; i++)
            if (pos < 0 && shadow_keys[i] == k)
                pos = i;
        case (op)
            lkvt_pkg::KIND_LOOKUP:
            begin
                if (pos >= 0)
                begin
                    r.found = 1'b1;
                    r.value = shadow_values[pos];
                end
            end
            lkvt_pkg::KIND_ACCESS:
            begin
                if (pos >= 0)
                begin
                    if (we)
                        shadow_values[pos] = wv;
                    r.found = 1'b1;
                    r.value = shadow_values[pos];
                end
                else if (shadow_count >= lkvt_pkg::CAPACITY)
                    r.status = lkvt_pkg::STATUS_FULL;
                else
                begin
                    // append at the end of the packed list
                    shadow_keys[shadow_count]   = k;
                    shadow_values[shadow_count] = we ? wv : '0;
                    r.value = shadow_values[shadow_count];
                    shadow_count++;
                end
            end
            lkvt_pkg::KIND_DELETE:
            begin
                if (pos >= 0)
                begin
                    // later entries move down one place
                    for (int i = pos + 1; i < shadow_count; i++)
                    begin
                        shadow_keys[i-1]   = shadow_keys[i];
                        shadow_values[i-1] = shadow_values[i];
                    end
                    shadow_count--;
                    r.found = 1'b1;
                end
                else
                    r.status = lkvt_pkg::STATUS_NOT_FOUND;
            end
            default:
                shadow_count = 0;
        endcase
        r.entry_count = shadow_count[lkvt_pkg::CNT_W-1:0];
        return r;
    endfunction

    // mostly keys from a pool a bit larger than the table, some fully random
    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 10)
            return $urandom;
        return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    endfunction

    // one input transfer, with an occasional idle gap before it
    task automatic issue_op(input logic [1:0] op, input logic [31:0] k,
                            input logic [31:0] wv, input logic we);
        if (!steady_mode && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= op;
        key          <= k;
        write_value  <= wv;
        write_enable <= we;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        table_results_due.push_back(apply_table_op(op, k, wv, we));
    endtask

    task automatic issue_random_op();
        int         pick;
        logic [1:0] op;
        pick = $urandom_range(99);
        if (pick < 26)
            op = lkvt_pkg::KIND_LOOKUP;
        else if (pick < 70)
            op = lkvt_pkg::KIND_ACCESS;
        else if (pick < 99)
            op = lkvt_pkg::KIND_DELETE;
        else
            op = lkvt_pkg::KIND_CLEAR;
        issue_op(op, pick_key(), $urandom, 1'($urandom_range(1)));
    endtask

    // stop sending until every result has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (table_results_due.size() != 0)
            @(posedge clk);
    endtask

    // extremes, every operation and the miss cases on a small table
    task automatic test_directed();
        issue_op(lkvt_pkg::KIND_LOOKUP, 32'h0, 32'h1234_5678, 1'b1);
        issue_op(lkvt_pkg::KIND_DELETE, MOST_NEGATIVE, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_NEGATIVE, 32'hFFFF_FFFF, 1'b0);
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_POSITIVE, MOST_NEGATIVE, 1'b1);
        issue_op(lkvt_pkg::KIND_ACCESS, 32'h0, 32'hFFFF_FFFF, 1'b1);
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_NEGATIVE, MOST_POSITIVE, 1'b1);
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_POSITIVE, 32'h0000_0001, 1'b0);
        issue_op(lkvt_pkg::KIND_LOOKUP, MOST_NEGATIVE, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_LOOKUP, 32'h1, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_DELETE, MOST_POSITIVE, 32'hFFFF_FFFF, 1'b1);
        issue_op(lkvt_pkg::KIND_LOOKUP, 32'h0, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_ACCESS, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        issue_op(lkvt_pkg::KIND_ACCESS, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        issue_op(lkvt_pkg::KIND_DELETE, MOST_NEGATIVE, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_DELETE, 32'hAAAA_AAAA, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_DELETE, MOST_POSITIVE, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_LOOKUP, 32'h5555_5555, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_CLEAR, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b1);
        issue_op(lkvt_pkg::KIND_LOOKUP, 32'h0, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_DELETE, 32'h0, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_ACCESS, 32'h0, 32'h0000_0001, 1'b1);
        issue_op(lkvt_pkg::KIND_CLEAR, 32'h0, 32'h0, 1'b0);
    endtask

    // fill to capacity, refuse inserts, delete the first entry, refill
    task automatic test_full_table();
        logic [31:0] fill_key;
        issue_op(lkvt_pkg::KIND_CLEAR, $urandom, $urandom, 1'b0);
        for (int i = 0; i < lkvt_pkg::CAPACITY; i++)
        begin
            fill_key = (i << 24) ^ 32'h005A_C396;
            issue_op(lkvt_pkg::KIND_ACCESS, fill_key, $urandom, 1'($urandom_range(1)));
        end
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_POSITIVE, $urandom, 1'b1);
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_NEGATIVE, $urandom, 1'b0);
        issue_op(lkvt_pkg::KIND_ACCESS, 32'h405A_C396, $urandom, 1'b1);
        issue_op(lkvt_pkg::KIND_LOOKUP, 32'h7F5A_C396, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_DELETE, 32'h005A_C396, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_LOOKUP, 32'h7F5A_C396, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_POSITIVE, $urandom, 1'b1);
        issue_op(lkvt_pkg::KIND_ACCESS, MOST_NEGATIVE, $urandom, 1'b1);
        issue_op(lkvt_pkg::KIND_LOOKUP, MOST_POSITIVE, 32'h0, 1'b0);
        issue_op(lkvt_pkg::KIND_CLEAR, $urandom, $urandom, 1'b1);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            issue_random_op();
    endtask

    // receiver holds off while the sender keeps offering, then sender drains
    task automatic test_backpressure();
        hold_output = 1'b1;
        test_random(30);
        wait_drain();
    endtask

    // a long stretch with no idling on either side
    task automatic test_steady_stretch();
        steady_mode = 1'b1;
        test_random(150);
        steady_mode = 1'b0;
    endtask

    // receiver: random stalls, or a long hold when asked
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_output)
            begin
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_output = 1'b0;
            end
            out_ready <= steady_mode || ($urandom_range(99) >= 12);
        end
    end

    // compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin : check_results
        lkvt_pkg::result_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (table_results_due.size() == 0)
            begin
                $error("result with no operation outstanding");
                mismatch_count++;
            end
            else
            begin
                due = table_results_due.pop_front();
                if (value !== due.value)
                begin
                    $error("value: expected %0d, got %0d", $signed(due.value), value);
                    mismatch_count++;
                end
                if (found !== due.found)
                begin
                    $error("found: expected %0d, got %0d", due.found, found);
                    mismatch_count++;
                end
                if (status !== due.status)
                begin
                    $error("status: expected %0d, got %0d", due.status, status);
                    mismatch_count++;
                end
                if (entry_count !== due.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", due.entry_count,
                           entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        kind           <= lkvt_pkg::KIND_LOOKUP;
        key            <= '0;
        write_value    <= '0;
        write_enable   <= 1'b0;
        mismatch_count = 0;
        steady_mode    = 1'b0;
        hold_output    = 1'b0;
        shadow_count   = 0;

        // pool with the extremes plus random keys
        key_pool[0] = MOST_NEGATIVE;
        key_pool[1] = MOST_POSITIVE;
        key_pool[2] = 32'h0;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_random(300);
        test_backpressure();
        test_steady_stretch();
        test_random(400);

        // let the last results come back, then watch for strays
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("linear_key_value_table test passed");
        else
            $display("linear_key_value_table test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/lkvt_pkg.sv
design/lkvt_ram.sv
design/lkvt_engine.sv
design/linear_key_value_table.sv
tb/sv/linear_key_value_table_tb.sv
